// ===== design/utf8_stream_sanitizer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef UTF8_STREAM_SANITIZER_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_ASSERT_SVH

// Implication checked at every clock edge while out of reset.
`define U8SS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define U8SS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/u8ss_pkg.sv =====
package u8ss_pkg;

    // Byte class patterns
    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD1_PAT  = 8'h00;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Held bytes of an open sequence, and result words per input word
    localparam int PEND_DEPTH = 3;
    localparam int BUF_DEPTH  = 4;

    // One result word
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } u8ss_res_t;

    // Sequence tracking state
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] seqlen;
    } u8ss_state_t;

    // Decoder outcome for one input word
    typedef struct packed {
        logic [2:0]                  n;
        u8ss_res_t [BUF_DEPTH-1:0]   res;
        u8ss_state_t                 nxt;
        logic                        pend_we;
        logic [1:0]                  pend_idx;
    } u8ss_dec_t;

endpackage

// ===== design/u8ss_decode.sv =====
module u8ss_decode
    import u8ss_pkg::*;
(
    input  logic [7:0]                  in_byte,
    input  logic                        in_last,
    input  u8ss_state_t                 st,
    input  logic [PEND_DEPTH-1:0][7:0]  pend,
    output u8ss_dec_t                   dec
);

    // Announced length of a lead byte, 0 if none
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & LEAD1_MASK) == LEAD1_PAT)      len = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_PAT) len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_PAT) len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_PAT) len = 3'd4;
        return len;
    endfunction

    logic       cont;
    logic [2:0] len;
    logic [2:0] held_plus;

    assign cont      = (in_byte & CONT_MASK) == CONT_PAT;
    assign len       = lead_length(in_byte);
    assign held_plus = {1'b0, st.count} + 3'd1;

    always_comb
    begin
        dec.n        = 3'd0;
        dec.nxt      = st;
        dec.pend_we  = 1'b0;
        dec.pend_idx = 2'd0;
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            dec.res[i] = '{data: in_byte, valid: 1'b1, last: 1'b0};
        end

        if (st.seqlen != 3'd0 && cont)
        begin
            if (held_plus >= st.seqlen)
            begin
                // sequence complete: held bytes, then this one
                for (int i = 0; i < PEND_DEPTH; i++)
                begin
                    if (2'(i) < st.count)
                    begin
                        dec.res[i].data = pend[i];
                    end
                end
                dec.n   = held_plus;
                dec.nxt = '0;
            end
            else
            begin
                dec.pend_we   = 1'b1;
                dec.pend_idx  = st.count;
                dec.nxt.count = st.count + 2'd1;
            end
        end
        else
        begin
            // no open sequence, or missing continuation: judge as lead
            dec.nxt = '0;
            if (len == 3'd1)
            begin
                dec.n = 3'd1;
            end
            else if (len >= 3'd2)
            begin
                dec.pend_we    = 1'b1;
                dec.pend_idx   = 2'd0;
                dec.nxt.count  = 2'd1;
                dec.nxt.seqlen = len;
            end
        end

        // end of string: drop unfinished sequence, mark last word
        if (in_last)
        begin
            dec.nxt = '0;
            if (dec.n == 3'd0)
            begin
                dec.n      = 3'd1;
                dec.res[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
            end
            else
            begin
                dec.res[2'(dec.n - 3'd1)].last = 1'b1;
            end
        end
    end

endmodule

// ===== design/utf8_stream_sanitizer.sv =====
// Channel   Handshake            Fields
// input     in_valid/in_stall    in_byte, in_last
// result    res_valid/res_stall  out_byte, out_valid, out_last
//
// One input word per cycle when not stalled; results leave one per cycle, when
// not stalled, from a 4-word buffer. A word that completes an n-byte sequence
// adds n results; input stalls only while the buffer lacks room for its words.
// Reset clears sequence state and the buffer; held bytes need no reset.
// A result stall holds the head word and backs up into the input channel.
module utf8_stream_sanitizer
    import u8ss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last
);

    u8ss_state_t                 st_reg, st_next;
    logic [PEND_DEPTH-1:0][7:0]  pend_reg;
    u8ss_res_t                   buf_reg  [BUF_DEPTH];
    u8ss_res_t                   buf_next [BUF_DEPTH];
    logic [2:0]                  cnt_reg, cnt_next;
    u8ss_dec_t                   dec;

    logic       pop;
    logic       accept;
    logic [2:0] kept;
    logic [3:0] fill;

    u8ss_decode u_decode (
        .in_byte (in_byte),
        .in_last (in_last),
        .st      (st_reg),
        .pend    (pend_reg),
        .dec     (dec)
    );

    // Handshakes
    assign res_valid = cnt_reg != 3'd0;
    assign pop       = res_valid && !res_stall;
    assign kept      = cnt_reg - {2'b00, pop};
    assign fill      = {1'b0, kept} + {1'b0, dec.n};
    assign in_stall  = fill > 4'(BUF_DEPTH);
    assign accept    = in_valid && !in_stall;

    assign out_byte  = buf_reg[0].data;
    assign out_valid = buf_reg[0].valid;
    assign out_last  = buf_reg[0].last;

    // Buffer: shift out head, append new results behind kept words
    always_comb
    begin
        logic [2:0] rel;
        for (int j = 0; j < BUF_DEPTH; j++)
        begin
            if (pop && j < BUF_DEPTH - 1)
            begin
                buf_next[j] = buf_reg[j + 1];
            end
            else
            begin
                buf_next[j] = buf_reg[j];
            end
            rel = 3'(j) - kept;
            if (accept && 3'(j) >= kept && rel < dec.n)
            begin
                buf_next[j] = dec.res[rel[1:0]];
            end
        end
        cnt_next = accept ? 3'(fill) : kept;
        st_next  = accept ? dec.nxt : st_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < BUF_DEPTH; j++)
        begin
            buf_reg[j] <= buf_next[j];
        end
        if (accept && dec.pend_we)
        begin
            pend_reg[dec.pend_idx] <= in_byte;
        end
    end

endmodule

// ===== design/u8ss_checker.sv =====
`include "utf8_stream_sanitizer_assert.svh"

module u8ss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic       out_last
);

    // A stalled result word stays offered
    `U8SS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result word withdrawn")

    // A bare end marker always closes the string
    `U8SS_ASSERT_IMP(a_bare_last, res_valid && !out_valid, out_last, "bare marker not last")

    // A bare end marker carries a zero byte
    `U8SS_ASSERT_IMP(a_bare_zero, res_valid && !out_valid, out_byte == 8'h00,
                     "bare marker byte not zero")

    // With the buffer empty, any input word fits
    `U8SS_ASSERT_IMP(a_empty_open, !res_valid, !in_stall, "input stalled with empty buffer")

    // An accepted ASCII byte or final word always leaves a result behind
    `U8SS_ASSERT_NEXT(a_word_result, in_valid && !in_stall && (in_last || !in_byte[7]),
                      res_valid, "accepted word gave no result")

endmodule

bind utf8_stream_sanitizer u8ss_checker u_checker (.*);
